// ----- rtl/kld_pkg.sv -----
// Shared types, constants and codes for the KL divergence accumulator.
package kld_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 24;
  localparam int SUM_W     = 48;
  localparam int LOG_FB    = 30;
  localparam int LOG_W     = LOG_FB + 5;
  localparam int TERM_W    = 30;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 3;

  localparam logic [27:0]      LN2_Q28  = 28'd186065279;
  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(LOG_FB - 1);
  localparam logic [ADDR_W-1:0] REG_USE_WEIGHTS = 3'd0;

  typedef struct packed {
    logic [VAL_W-1:0]        data_value;
    logic [VAL_W-1:0]        approx_value;
    logic signed [VAL_W-1:0] weight;
    logic                    last;
  } in_data_t;

  typedef struct packed {
    logic [SUM_W-1:0] divergence_total;
    logic             saturated;
  } out_data_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_NORM,
    ST_SQ,
    ST_MAG,
    ST_LN_LO,
    ST_LN_HI,
    ST_PR_LO,
    ST_PR_HI,
    ST_TERM,
    ST_WMUL,
    ST_ACC
  } state_t;

  typedef enum logic [2:0] {
    MUL_SQ,
    MUL_LN_LO,
    MUL_LN_HI,
    MUL_PR_LO,
    MUL_PR_HI,
    MUL_WT
  } mul_op_t;

  typedef struct packed {
    logic [LOG_FB:0]     mant;
    logic [LOG_W-1:0]    mag;
    logic [LOG_W-1:0]    lnm;
    logic [VAL_W-1:0]    v;
    logic [TERM_W-1:0]   term;
    logic [VAL_W-2:0]    w;
  } mul_opnd_t;

endpackage

// ----- rtl/kld_mul.sv -----
// Shared 32x32 multiplier with operand selection for each sequencer step.
module kld_mul
  import kld_pkg::*;
(
  input  mul_op_t     op,
  input  mul_opnd_t   opnd,
  output logic [63:0] product
);

  logic [31:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    case (op)
      MUL_SQ: begin
        mul_a = 32'(opnd.mant);
        mul_b = 32'(opnd.mant);
      end
      MUL_LN_LO: begin
        mul_a = opnd.mag[31:0];
        mul_b = 32'(LN2_Q28);
      end
      MUL_LN_HI: begin
        mul_a = 32'(opnd.mag[LOG_W-1:32]);
        mul_b = 32'(LN2_Q28);
      end
      MUL_PR_LO: begin
        mul_a = opnd.lnm[31:0];
        mul_b = 32'(opnd.v);
      end
      MUL_PR_HI: begin
        mul_a = 32'(opnd.lnm[LOG_W-1:32]);
        mul_b = 32'(opnd.v);
      end
      MUL_WT: begin
        mul_a = 32'(opnd.term);
        mul_b = 32'(opnd.w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = 64'(mul_a) * 64'(mul_b);

endmodule

// ----- rtl/weighted_kl_divergence_accumulator.sv -----
// Top level of the weighted generalized KL divergence accumulator.
//
// Items arrive on in_valid/in_stall as (data_value, approx_value, weight, last),
// all Q8.16. Each transfer adds v*ln(v/a) - v + a, optionally scaled by the
// weight, to a 48-bit Q32.16 running sum that saturates at its maximum.
// The item marked last produces one result transfer on out_valid/out_stall
// carrying the total and the saturation flag; both are then cleared.
// A single shared multiplier does all the work under a sequencer. The two
// logarithms take 30 squaring steps each; skipped, zero-data and infinite
// items bypass them. in_stall stays high while an item is in work, so the
// block takes no new item until the previous one is accumulated.
// The result register sits after the sequencer: while out_stall holds a
// result, the block still works the next item and only waits if another
// last item finishes before the held result is taken.
// use_weights is written through the APB port at address 0 and reads back.
// Synchronous reset clears the sum, the flag, use_weights and all control.
module weighted_kl_divergence_accumulator
  import kld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_data_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_data_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  state_t state_r, state_nxt;

  logic [VAL_W-1:0]  v_r, a_r, w_r;
  logic              last_r;
  logic              use_w_r;
  logic [LOG_FB:0]   m_r, m_nxt;
  logic [LOG_FB-1:0] f_r, f_nxt;
  logic [4:0]        p_r, p_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sel_a_r, sel_a_nxt;
  logic [LOG_W-1:0]  lv_r, lv_nxt, la_r, la_nxt, mag_r, mag_nxt, lnm_r, lnm_nxt;
  logic              positive_r, positive_nxt;
  logic [59:0]       acc_r, acc_nxt;
  logic [SUM_W-1:0]  term_r, term_nxt;
  logic              inf_r, inf_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              ovf_r, ovf_nxt;
  out_data_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  mul_op_t     mul_op;
  mul_opnd_t   mul_opnd;
  logic [63:0] product;

  logic             in_xfer;
  logic             skip;
  logic             out_busy;
  logic [VAL_W-1:0] norm_x;
  logic [4:0]       norm_p;
  logic [31:0]      sq;
  logic [63:0]      ln_tot;
  logic [60:0]      pos_v, neg_v, diff_v;
  logic [63:0]      wt_v;
  logic [SUM_W:0]   add_v;

  function automatic logic [4:0] msb_pos(input logic [VAL_W-1:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  kld_mul u_mul (
    .op      (mul_op),
    .opnd    (mul_opnd),
    .product (product)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_USE_WEIGHTS) ? {31'b0, use_w_r} : 32'b0;

  assign skip     = use_w_r && (w_r[VAL_W-1] || (w_r == '0));
  assign out_busy = out_valid_r && out_stall;
  assign norm_x   = sel_a_r ? a_r : v_r;
  assign norm_p   = msb_pos(norm_x);
  assign sq       = product[61:30];

  assign mul_opnd.mant = m_r;
  assign mul_opnd.mag  = mag_r;
  assign mul_opnd.lnm  = lnm_r;
  assign mul_opnd.v    = v_r;
  assign mul_opnd.term = term_r[TERM_W-1:0];
  assign mul_opnd.w    = w_r[VAL_W-2:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_START;
      ST_START: begin
        if (skip || (v_r != '0 && a_r == '0)) begin
          state_nxt = ST_ACC;
        end else if (v_r == '0) begin
          state_nxt = use_w_r ? ST_WMUL : ST_ACC;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM:  state_nxt = ST_SQ;
      ST_SQ:    if (cnt_r == SQ_LAST) state_nxt = sel_a_r ? ST_MAG : ST_NORM;
      ST_MAG:   state_nxt = ST_LN_LO;
      ST_LN_LO: state_nxt = ST_LN_HI;
      ST_LN_HI: state_nxt = ST_PR_LO;
      ST_PR_LO: state_nxt = ST_PR_HI;
      ST_PR_HI: state_nxt = ST_TERM;
      ST_TERM:  state_nxt = use_w_r ? ST_WMUL : ST_ACC;
      ST_WMUL:  state_nxt = ST_ACC;
      ST_ACC:   if (!(last_r && out_busy)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    m_nxt         = m_r;
    f_nxt         = f_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    sel_a_nxt     = sel_a_r;
    lv_nxt        = lv_r;
    la_nxt        = la_r;
    mag_nxt       = mag_r;
    lnm_nxt       = lnm_r;
    positive_nxt  = positive_r;
    acc_nxt       = acc_r;
    term_nxt      = term_r;
    inf_nxt       = inf_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_op        = MUL_SQ;
    ln_tot        = '0;
    pos_v         = '0;
    neg_v         = '0;
    diff_v        = '0;
    wt_v          = '0;
    add_v         = '0;
    case (state_r)
      ST_START: begin
        sel_a_nxt = 1'b0;
        inf_nxt   = !skip && (v_r != '0) && (a_r == '0);
        term_nxt  = (!skip && v_r == '0) ? SUM_W'(a_r) : '0;
      end
      ST_NORM: begin
        m_nxt   = (LOG_FB + 1)'(norm_x) << (5'(LOG_FB) - norm_p);
        p_nxt   = norm_p;
        cnt_nxt = '0;
        f_nxt   = '0;
      end
      ST_SQ: begin
        mul_op  = MUL_SQ;
        m_nxt   = sq[31] ? sq[31:1] : sq[30:0];
        f_nxt   = {f_r[LOG_FB-2:0], sq[31]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          if (sel_a_r) begin
            la_nxt = {p_r, f_nxt};
          end else begin
            lv_nxt = {p_r, f_nxt};
          end
          sel_a_nxt = 1'b1;
        end
      end
      ST_MAG: begin
        positive_nxt = lv_r >= la_r;
        mag_nxt      = (lv_r >= la_r) ? lv_r - la_r : la_r - lv_r;
      end
      ST_LN_LO: begin
        mul_op  = MUL_LN_LO;
        acc_nxt = product[59:0];
      end
      ST_LN_HI: begin
        mul_op  = MUL_LN_HI;
        ln_tot  = 64'(acc_r) + {product[31:0], 32'b0};
        lnm_nxt = ln_tot[62:28];
      end
      ST_PR_LO: begin
        mul_op  = MUL_PR_LO;
        acc_nxt = product[59:0];
      end
      ST_PR_HI: begin
        mul_op  = MUL_PR_HI;
        acc_nxt = acc_r + {product[27:0], 32'b0};
      end
      ST_TERM: begin
        pos_v = {7'b0, a_r, 30'b0} + (positive_r ? 61'(acc_r) : 61'b0);
        neg_v = {7'b0, v_r, 30'b0} + (positive_r ? 61'b0 : 61'(acc_r));
        diff_v = pos_v - neg_v + 61'(1 << (LOG_FB - 1));
        term_nxt = (pos_v <= neg_v) ? '0 : SUM_W'(diff_v[LOG_FB + TERM_W - 1:LOG_FB]);
      end
      ST_WMUL: begin
        mul_op   = MUL_WT;
        wt_v     = product + 64'(1 << (FRAC_BITS - 1));
        term_nxt = wt_v[FRAC_BITS + SUM_W - 1:FRAC_BITS];
      end
      ST_ACC: begin
        if (!(last_r && out_busy)) begin
          add_v = {1'b0, sum_r} + {1'b0, term_r};
          if (inf_r || add_v[SUM_W]) begin
            sum_nxt = SUM_MAX;
            ovf_nxt = 1'b1;
          end else begin
            sum_nxt = add_v[SUM_W-1:0];
          end
          if (last_r) begin
            out_nxt.divergence_total = sum_nxt;
            out_nxt.saturated        = ovf_nxt;
            out_valid_nxt            = 1'b1;
            sum_nxt                  = '0;
            ovf_nxt                  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      use_w_r     <= 1'b0;
      cnt_r       <= '0;
      sel_a_r     <= 1'b0;
      inf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sel_a_r     <= sel_a_nxt;
      inf_r       <= inf_nxt;
      if (psel && penable && pwrite && (paddr == REG_USE_WEIGHTS)) begin
        use_w_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      v_r    <= in_data.data_value;
      a_r    <= in_data.approx_value;
      w_r    <= in_data.weight;
      last_r <= in_data.last;
    end
    m_r        <= m_nxt;
    f_r        <= f_nxt;
    p_r        <= p_nxt;
    lv_r       <= lv_nxt;
    la_r       <= la_nxt;
    mag_r      <= mag_nxt;
    lnm_r      <= lnm_nxt;
    positive_r <= positive_nxt;
    acc_r      <= acc_nxt;
    term_r     <= term_nxt;
    out_r      <= out_nxt;
  end

  // The flag is only ever set together with a pinned sum.
  a_ovf_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (sum_r == SUM_MAX))
    else $error("overflow flag set without saturated sum");

  // A new result only comes from the accumulate step of a last item.
  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ACC && last_r))
    else $error("result raised outside accumulate step");

  // After a result is produced the running state starts over.
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && last_r && !out_busy) |=> (sum_r == '0 && !ovf_r))
    else $error("running sum not cleared after result");

  // The squaring counter never runs past the last fraction bit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (cnt_r <= SQ_LAST))
    else $error("squaring counter out of range");

endmodule
